[rtl/twbp_pkg.sv]
// Shared types and constants of the tolerance-window peak matcher.
package twbp_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam logic [1:0] CFG_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_MZ_GAIN  = 2'd1;
    localparam logic [1:0] CFG_INT_GAIN = 2'd2;
    localparam logic [1:0] CFG_CEILING  = 2'd3;

    localparam int          LOG_W     = 13;
    localparam logic [2:0]  LAST_STEP = 3'd7;
    localparam logic [47:0] SCORE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]       op;
        logic [31:0]      mz;
        logic [31:0]      inten;
        logic [LOG_W-1:0] lg;
    } t_item;

    typedef struct packed {
        logic [19:0] window;
        logic [31:0] mz_gain;
        logic [31:0] int_gain;
        logic [47:0] ceiling;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [9:0]  index;
        logic [31:0] mz;
        logic [31:0] inten;
        logic [47:0] score;
        logic [10:0] count;
    } t_result;

    typedef enum logic [1:0] {F_IDLE, F_LOG, F_PUSH} t_front_state;

    typedef enum logic [3:0] {
        B_IDLE, B_DISPATCH, B_BCHK, B_BCMP, B_SREAD, B_SCHK, B_SQ,
        B_MH, B_ML, B_IT, B_SUM, B_CMP, B_NEXT, B_DONE
    } t_back_state;

endpackage

[rtl/twbp_ram.sv]
// Simple dual-port RAM with registered read.
module twbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/twbp_fifo.sv]
// Two-entry queue between front and back.
module twbp_fifo import twbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

[rtl/twbp_front.sv]
// Front end: takes transactions and computes the Q8 log2 of the intensity.
module twbp_front import twbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_peak_mz,
    input  logic [31:0] i_peak_intensity,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);
    t_front_state r_state, n_state;
    t_item        r_item, n_item;
    logic [31:0]  r_m, n_m;
    logic [2:0]   r_step, n_step;
    logic [4:0]   lead_p;
    logic [63:0]  sq;
    logic [32:0]  sq_t;

    always_comb begin
        lead_p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_peak_intensity[i]) begin
                lead_p = 5'(i);
            end
        end
    end

    assign sq   = 64'(r_m) * 64'(r_m);
    assign sq_t = sq[63:31];

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_m        = r_m;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item.op    = i_operation;
                    n_item.mz    = i_peak_mz;
                    n_item.inten = i_peak_intensity;
                    n_item.lg    = {lead_p, 8'd0};
                    n_m          = i_peak_intensity << (5'd31 - lead_p);
                    n_step       = 3'd0;
                    if ((i_operation == OP_LOAD || i_operation == OP_QUERY) &&
                        i_peak_intensity != 32'd0) begin
                        n_state = F_LOG;
                    end else begin
                        n_item.lg = '0;
                        n_state   = F_PUSH;
                    end
                end
            end
            F_LOG: begin
                // one fraction bit per squaring
                n_item.lg[7:0] = {r_item.lg[6:0], sq_t[32]};
                n_m            = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                n_step         = r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_m    <= n_m;
        r_step <= n_step;
    end

    assign o_item = r_item;
endmodule

[rtl/twbp_back.sv]
// Back end: peak table, binary search, window scan and scoring.
module twbp_back import twbp_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_empty,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_back_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_last_mz, n_last_mz;
    t_item            r_cur, n_cur;
    logic [32:0]      r_upper, n_upper;
    logic [CW-1:0]    r_lo, n_lo, r_hi, n_hi, r_k, n_k;
    logic [31:0]      r_d, n_d;
    logic [LOG_W-1:0] r_ld, n_ld;
    logic [63:0]      r_sq, n_sq, r_mzh, n_mzh;
    logic [31:0]      r_mzl, n_mzl;
    logic [36:0]      r_it, n_it;
    logic [47:0]      r_score, n_score;
    logic [31:0]      r_cand_mz, n_cand_mz, r_cand_int, n_cand_int;
    logic             r_found, n_found;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    logic [31:0]      r_best_mz, n_best_mz, r_best_int, n_best_int;
    logic [47:0]      r_best_score, n_best_score;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic [CW-1:0]    mid;
    logic [CW:0]      mid_sum;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [31:0]      rd_mz, rd_int;
    logic [LOG_W-1:0] rd_lg;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic [48:0]      mzt, ssum;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign prod    = 64'(mul_a) * 64'(mul_b);
    assign we      = (r_state == B_DISPATCH) && (r_cur.op == OP_LOAD) &&
                     (r_count != CW'(TABLE_DEPTH)) &&
                     !(r_count != '0 && r_cur.mz < r_last_mz);

    twbp_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_mz_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_count[AW-1:0]), .i_wdata(r_cur.mz),
        .i_raddr(raddr), .o_rdata(rd_mz)
    );
    twbp_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_int_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_count[AW-1:0]), .i_wdata(r_cur.inten),
        .i_raddr(raddr), .o_rdata(rd_int)
    );
    twbp_ram #(.WIDTH(LOG_W), .DEPTH(TABLE_DEPTH)) u_log_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_count[AW-1:0]), .i_wdata(r_cur.lg),
        .i_raddr(raddr), .o_rdata(rd_lg)
    );

    always_comb begin
        n_state = r_state;      n_count = r_count;       n_last_mz = r_last_mz;
        n_cur = r_cur;          n_upper = r_upper;       n_lo = r_lo;
        n_hi = r_hi;            n_k = r_k;               n_d = r_d;
        n_ld = r_ld;            n_sq = r_sq;             n_mzh = r_mzh;
        n_mzl = r_mzl;          n_it = r_it;             n_score = r_score;
        n_cand_mz = r_cand_mz;  n_cand_int = r_cand_int; n_found = r_found;
        n_best_idx = r_best_idx; n_best_mz = r_best_mz;  n_best_int = r_best_int;
        n_best_score = r_best_score; n_status = r_status;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop = 1'b0;
        raddr = '0;
        mul_a = r_d;
        mul_b = r_d;
        mzt   = {1'b0, r_mzh[47:0]} + 49'(r_mzl);
        ssum  = {1'b0, mzt[47:0]} + 49'(r_it);
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cur   = i_item;
                    n_state = B_DISPATCH;
                end
            end
            B_DISPATCH: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                n_state  = B_DONE;
                case (r_cur.op)
                    OP_LOAD: begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else if (r_count != '0 && r_cur.mz < r_last_mz) begin
                            n_status = ST_ORDER;
                        end else begin
                            n_count   = r_count + CW'(1);
                            n_last_mz = r_cur.mz;
                        end
                    end
                    OP_QUERY: begin
                        n_upper = {1'b0, r_cur.mz} + 33'(i_cfg.window);
                        n_lo    = '0;
                        n_hi    = r_count;
                        if (r_cur.inten != 32'd0 && r_count != '0) begin
                            n_state = B_BCHK;
                        end
                    end
                    OP_CLEAR: n_count = '0;
                    default: ;
                endcase
            end
            B_BCHK: begin
                // first index whose mz lies above the window
                if (r_lo < r_hi) begin
                    raddr   = mid[AW-1:0];
                    n_state = B_BCMP;
                end else begin
                    n_k     = r_lo;
                    n_state = (r_lo == '0) ? B_DONE : B_SREAD;
                end
            end
            B_BCMP: begin
                raddr = mid[AW-1:0];
                if ({1'b0, rd_mz} > r_upper) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + CW'(1);
                end
                n_state = B_BCHK;
            end
            B_SREAD: begin
                raddr   = AW'(r_k - CW'(1));
                n_state = B_SCHK;
            end
            B_SCHK: begin
                n_cand_mz  = rd_mz;
                n_cand_int = rd_int;
                n_d  = (rd_mz > r_cur.mz) ? rd_mz - r_cur.mz : r_cur.mz - rd_mz;
                n_ld = (rd_lg > r_cur.lg) ? rd_lg - r_cur.lg : r_cur.lg - rd_lg;
                if ({1'b0, rd_mz} + 33'(i_cfg.window) <= {1'b0, r_cur.mz}) begin
                    n_state = B_DONE;
                end else if (rd_int == 32'd0) begin
                    n_state = B_NEXT;
                end else begin
                    n_state = B_SQ;
                end
            end
            B_SQ: begin
                n_sq    = prod;
                n_state = B_MH;
            end
            B_MH: begin
                mul_a   = i_cfg.mz_gain;
                mul_b   = r_sq[63:32];
                n_mzh   = prod;
                n_state = B_ML;
            end
            B_ML: begin
                mul_a   = i_cfg.mz_gain;
                mul_b   = r_sq[31:0];
                n_mzl   = prod[63:32];
                n_state = B_IT;
            end
            B_IT: begin
                mul_a   = i_cfg.int_gain;
                mul_b   = 32'(r_ld);
                n_it    = prod[44:8];
                n_state = B_SUM;
            end
            B_SUM: begin
                if (r_mzh > 64'(SCORE_MAX) || mzt[48] || ssum[48]) begin
                    n_score = SCORE_MAX;
                end else begin
                    n_score = ssum[47:0];
                end
                n_state = B_CMP;
            end
            B_CMP: begin
                // strict compare: on a tie the higher index, seen first, stays
                if (r_score < i_cfg.ceiling && (!r_found || r_score < r_best_score)) begin
                    n_found      = 1'b1;
                    n_best_score = r_score;
                    n_best_idx   = AW'(r_k - CW'(1));
                    n_best_mz    = r_cand_mz;
                    n_best_int   = r_cand_int;
                end
                n_state = B_NEXT;
            end
            B_NEXT: begin
                n_k     = r_k - CW'(1);
                n_state = (r_k == CW'(1)) ? B_DONE : B_SREAD;
            end
            B_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status = r_status;
                    n_out.found  = r_found;
                    n_out.index  = r_found ? 10'(r_best_idx) : 10'd0;
                    n_out.mz     = r_found ? r_best_mz : 32'd0;
                    n_out.inten  = r_found ? r_best_int : 32'd0;
                    n_out.score  = r_found ? r_best_score : 48'd0;
                    n_out.count  = 11'(r_count);
                    n_out_valid  = 1'b1;
                    n_state      = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_last_mz <= n_last_mz;   r_cur <= n_cur;           r_upper <= n_upper;
        r_lo <= n_lo;             r_hi <= n_hi;             r_k <= n_k;
        r_d <= n_d;               r_ld <= n_ld;             r_sq <= n_sq;
        r_mzh <= n_mzh;           r_mzl <= n_mzl;           r_it <= n_it;
        r_score <= n_score;       r_cand_mz <= n_cand_mz;   r_cand_int <= n_cand_int;
        r_found <= n_found;       r_best_idx <= n_best_idx; r_best_mz <= n_best_mz;
        r_best_int <= n_best_int; r_best_score <= n_best_score;
        r_status <= n_status;     r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
endmodule

[rtl/tolerance_window_best_peak_match_top.sv]
// Top level of the tolerance-window best peak matcher.
// Loads, queries and clears go through a front end that takes one transaction
// at a time and a back end that owns the peak table; a two-entry queue lets
// the two overlap. For a load or query with nonzero intensity the front runs
// 8 squaring steps of the log2 unit; other transactions skip them.
// In the back a query runs a binary search over the mz RAM (one read port,
// registered) and then scans every peak inside the window, where the shared
// 32x32 multiplier is used four times per peak; a stored peak of zero
// intensity skips the multiplier. Loads, clears and queries also pass through
// dispatch and output. Throughput follows the slower of the two ends.
// The result register frees the back end as soon as the result is taken.
module tolerance_window_best_peak_match_top import twbp_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_peak_mz,
    input  logic [31:0] i_peak_intensity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [9:0]  o_match_index,
    output logic [31:0] o_match_mz,
    output logic [31:0] o_match_intensity,
    output logic [47:0] o_match_score,
    output logic [10:0] o_table_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    t_cfg    r_cfg;
    t_item   front_item, fifo_item;
    logic    push, pop, full, empty;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window   <= 20'd1311;
            r_cfg.mz_gain  <= 32'd65536;
            r_cfg.int_gain <= 32'd256;
            r_cfg.ceiling  <= 48'd100000000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW:   r_cfg.window   <= i_cfg_data[19:0];
                CFG_MZ_GAIN:  r_cfg.mz_gain  <= i_cfg_data[31:0];
                CFG_INT_GAIN: r_cfg.int_gain <= i_cfg_data[31:0];
                CFG_CEILING:  r_cfg.ceiling  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    twbp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_operation(i_operation), .i_peak_mz(i_peak_mz),
        .i_peak_intensity(i_peak_intensity), .o_push(push), .o_item(front_item),
        .i_full(full)
    );

    twbp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(front_item),
        .i_pop(pop), .o_item(fifo_item), .o_full(full), .o_empty(empty)
    );

    twbp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_empty(empty),
        .i_item(fifo_item), .o_pop(pop), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_result(result)
    );

    assign o_status          = result.status;
    assign o_found           = result.found;
    assign o_match_index     = result.index;
    assign o_match_mz        = result.mz;
    assign o_match_intensity = result.inten;
    assign o_match_score     = result.score;
    assign o_table_count     = result.count;

    a_found_below_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_match_score < r_cfg.ceiling)
        else $error("match score not below ceiling");

    a_reject_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> !o_found)
        else $error("rejected load reports a match");

    a_match_nonzero_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_match_intensity != 32'd0)
        else $error("match with zero intensity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_table_count) <= 32'(TABLE_DEPTH))
        else $error("table count above depth");
endmodule
